>>> hw/rtl/ssrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_pkg: shared types and constants for the swerve settle ramp gate
// Register indexes, drive modes, the state machine encoding and the divider control.
// ----------------------------------------------------------------------------
package ssrg_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int TIME_BITS_DEF       = 32;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    localparam logic [2:0] CFG_THRESH  = 3'd0;
    localparam logic [2:0] CFG_RUP     = 3'd1;
    localparam logic [2:0] CFG_RDOWN   = 3'd2;
    localparam logic [2:0] CFG_REVSQ   = 3'd3;
    localparam logic [2:0] CFG_EPS     = 3'd4;
    localparam logic [2:0] CFG_CAPS    = 3'd5;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_STEER  = 3'd1;
    localparam logic [2:0] MODE_RUP    = 3'd2;
    localparam logic [2:0] MODE_DRIVE  = 3'd3;
    localparam logic [2:0] MODE_RDOWN  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SPD   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } seq_state_t;

    // divider control between sequencer and serial divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

endpackage

>>> hw/rtl/ssrg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_if: valid/ready request channel
// Carries one payload word between a source and a sink.
// ----------------------------------------------------------------------------
interface ssrg_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ssrg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_div: bit-serial restoring divider
// Computes num / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssrg_div
    import ssrg_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quot,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

`ifndef SYNTH
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
`endif
endmodule

>>> hw/rtl/ssrg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_mul: bit-serial shift-add multiplier
// Signed value times an unsigned scale, one scale bit per cycle.
// ----------------------------------------------------------------------------
module ssrg_mul
    import ssrg_pkg::*;
#(
    parameter int AW = 16,
    parameter int BW = 17
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [AW-1:0] a,
    input  logic [BW-1:0]       b,
    output logic signed [AW+BW:0] prod,
    output logic                done
);
    localparam int CW = $clog2(BW + 1);

    logic signed [AW+BW:0] acc_reg, acc_next;
    logic signed [AW+BW:0] a_reg, a_next;
    logic [BW-1:0]         b_reg, b_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = (AW+BW+1)'(a);
            b_next    = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;

`ifndef SYNTH
    a_mdone_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("multiplier done held");
    a_mstart: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("multiplier did not start");
    a_mdone_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
`endif
endmodule

>>> hw/rtl/swerve_settle_ramp_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_settle_ramp_gate: settle-then-ramp speed gate for four swerve modules
// Gates wheel speed on steer settling and ramps it up and down in time.
// ----------------------------------------------------------------------------
// usage
//  in : one request per control update: body command, timestamp and the
//       packed target angles, measured angles and wheel speeds
//  out: one request per update: steer commands, drive commands, mode, scale
//  cfg: write port, cfg_index selects the register, taken at any time idle
// sequencing
//  one update at a time, worked by the bit-serial divider (one quotient
//  bit a cycle over up to 49 bits, run at most once per update for the
//  ramp scale, also when a ramp-down starts from ramping up) and the
//  bit-serial multiplier (17 scale bits per wheel, four wheels in turn)
// reset
//  registers back to their defaults, mode idle, all held state zero
// stall
//  a finished result is held in the output register until taken; the
//  input is not taken again until the result has gone
// ----------------------------------------------------------------------------
module swerve_settle_ramp_gate
    import ssrg_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [15:0]  cmd_vx,
    input  logic [15:0]  cmd_vy,
    input  logic [15:0]  cmd_wz,
    input  logic [31:0]  now_time,
    input  logic [63:0]  target_angles,
    input  logic [63:0]  measured_angles,
    input  logic [63:0]  wheel_speeds,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  steer_commands,
    output logic [63:0]  drive_commands,
    output logic [2:0]   drive_mode,
    output logic [16:0]  drive_scale
);
    localparam int SW  = SCALE_FRAC_BITS + 1;
    localparam logic [SW-1:0] FULL = SW'(1) << SCALE_FRAC_BITS;
    localparam int NW  = TIME_BITS + SW;

    // configuration
    logic [14:0]          thr_reg, eps_reg;
    logic [TIME_BITS-1:0] rup_reg, rdn_reg;
    logic [31:0]          rsq_reg;
    logic [63:0]          caps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 15'd205;
            rup_reg  <= TIME_BITS'(500000);
            rdn_reg  <= TIME_BITS'(500000);
            rsq_reg  <= 32'd164;
            eps_reg  <= 15'd1;
            caps_reg <= 64'hFFFF7FFFFFFFFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESH: thr_reg  <= cfg_data[14:0];
                CFG_RUP:    rup_reg  <= cfg_data[TIME_BITS-1:0];
                CFG_RDOWN:  rdn_reg  <= cfg_data[TIME_BITS-1:0];
                CFG_REVSQ:  rsq_reg  <= cfg_data[31:0];
                CFG_EPS:    eps_reg  <= cfg_data[14:0];
                CFG_CAPS:   caps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // channels
    ssrg_if #(.W(16)) in_ch ();
    assign in_ch.valid = in_valid;
    assign in_ch.data  = cmd_vx;
    assign in_ready    = in_ch.ready;

    // held state
    logic [2:0]            mode_reg, mode_next;
    logic [TIME_BITS-1:0]  rstart_reg, rstart_next;
    logic [SW-1:0]         rfrom_reg, rfrom_next;
    logic [63:0]           last_reg, last_next, lsteer_reg, lsteer_next;
    logic [63:0]           lspeed_reg, lspeed_next;
    logic signed [15:0]    pvx_reg, pvx_next, pvy_reg, pvy_next;

    // per-update working registers
    seq_state_t            st_reg, st_next;
    logic [63:0]           spd_reg, spd_next;       // capped speeds
    logic [63:0]           tgt_reg, tgt_next;
    logic                  stop_reg, stop_next, uns_reg, uns_next, rev_reg, rev_next;
    logic [TIME_BITS-1:0]  now_reg, now_next, el_reg, el_next;
    logic [1:0]            phase_reg, phase_next;   // which division runs
    logic [1:0]            lane_reg, lane_next;
    logic [SW-1:0]         scale_reg, scale_next;
    logic [63:0]           steer_reg, steer_next, drive_reg, drive_next;
    logic                  ov_reg, ov_next;

    // divider and multiplier
    div_ctrl_t             dctl;
    logic [NW-1:0]         div_num, div_q;
    logic [TIME_BITS-1:0]  div_den;
    logic                  mul_start, mul_done;
    logic signed [15:0]    mul_a;
    logic signed [16+SW:0] mul_p;

    ssrg_div #(.NW(NW), .DW(TIME_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dctl.start), .num(div_num),
        .den(div_den), .quot(div_q), .done(dctl.done));
    assign dctl.busy = 1'b0;

    ssrg_mul #(.AW(16), .BW(SW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(scale_reg),
        .prod(mul_p), .done(mul_done));

    assign in_ch.ready = (st_reg == ST_IDLE) && !ov_reg;

    // input decode, combinational over the four lanes and the body command
    logic [63:0]  cap_spd, tgt_ext;
    logic         unsettled, stop, reversal;
    logic signed [16:0] e;
    logic signed [ANGLE_BITS-1:0] ta, ma;
    logic signed [15:0] s, c, vx, vy, wz;
    logic signed [32:0] dot, psq, csq;
    logic [15:0] avx, avy, awz;

    always_comb
    begin
        unsettled = 1'b0;
        cap_spd   = '0;
        tgt_ext   = '0;
        for (int i = 0; i < 4; i++)
        begin
            s  = wheel_speeds[16*i +: 16];
            c  = caps_reg[16*i +: 16];
            cap_spd[16*i +: 16] = (s > c) ? c : s;
            ta = target_angles[16*i +: ANGLE_BITS];
            ma = measured_angles[16*i +: ANGLE_BITS];
            tgt_ext[16*i +: 16] = 16'(ta);
            e  = 17'(ta) - 17'(ma);
            if (e < 0)
                e = -e;
            if (e > $signed({2'b0, thr_reg}))
                unsettled = 1'b1;
        end
        vx  = cmd_vx;
        vy  = cmd_vy;
        wz  = cmd_wz;
        avx = vx[15] ? 16'(-vx) : vx;
        avy = vy[15] ? 16'(-vy) : vy;
        awz = wz[15] ? 16'(-wz) : wz;
        stop = (avx < {1'b0, eps_reg}) && (avy < {1'b0, eps_reg})
            && (awz < {1'b0, eps_reg});
        dot = 33'(vx * pvx_reg) + 33'(vy * pvy_reg);
        psq = 33'(pvx_reg * pvx_reg) + 33'(pvy_reg * pvy_reg);
        csq = 33'(vx * vx) + 33'(vy * vy);
        reversal = dot[32] && (psq[31:0] > rsq_reg) && (csq[31:0] > rsq_reg);
    end

    logic [NW-1:0]        q_sat;
    logic [SW-1:0]        up_val;
    logic [TIME_BITS-1:0] el_now;

    always_comb
    begin
        q_sat  = div_q;
        up_val = (q_sat > NW'(FULL)) ? FULL : q_sat[SW-1:0];
        el_now = now_time - rstart_reg;
    end

    always_comb
    begin
        st_next     = st_reg;
        mode_next   = mode_reg;
        rstart_next = rstart_reg;
        rfrom_next  = rfrom_reg;
        last_next   = last_reg;
        lsteer_next = lsteer_reg;
        lspeed_next = lspeed_reg;
        pvx_next    = pvx_reg;
        pvy_next    = pvy_reg;
        spd_next    = spd_reg;
        tgt_next    = tgt_reg;
        stop_next   = stop_reg;
        uns_next    = uns_reg;
        rev_next    = rev_reg;
        now_next    = now_reg;
        el_next     = el_reg;
        phase_next  = phase_reg;
        lane_next   = lane_reg;
        scale_next  = scale_reg;
        steer_next  = steer_reg;
        drive_next  = drive_reg;
        ov_next     = ov_reg;
        dctl.start  = 1'b0;
        div_num     = '0;
        div_den     = rup_reg;
        mul_start   = 1'b0;
        mul_a       = spd_reg[16*lane_reg +: 16];
        if (mode_reg == MODE_RDOWN)
            mul_a = lspeed_reg[16*lane_reg +: 16];

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ch.ready)
                begin
                    spd_next  = cap_spd;
                    tgt_next  = tgt_ext;
                    stop_next = stop;
                    uns_next  = unsettled;
                    rev_next  = reversal;
                    now_next  = now_time;
                    el_next   = el_now;
                    if (!stop)
                    begin
                        lspeed_next = cap_spd;
                        pvx_next    = cmd_vx;
                        pvy_next    = cmd_vy;
                    end
                    st_next = ST_SPD;
                end
            end
            ST_SPD:
            begin
                // decide the transition, start a division where one is due
                lane_next = 2'd0;
                st_next   = ST_MUL;
                if (mode_reg == MODE_RDOWN)
                begin
                    if (rdn_reg != '0 && el_reg < rdn_reg)
                    begin
                        div_num    = NW'(rfrom_reg) * NW'(rdn_reg - el_reg);
                        div_den    = rdn_reg;
                        dctl.start = 1'b1;
                        phase_next = 2'd0;
                        st_next    = ST_DIV;
                    end
                    else
                    begin
                        scale_next = '0;
                        if (stop_reg)
                            mode_next = MODE_IDLE;
                        else if (uns_reg)
                            mode_next = MODE_STEER;
                        else
                        begin
                            mode_next   = MODE_RUP;
                            rstart_next = now_reg;
                        end
                    end
                end
                else if ((uns_reg || rev_reg || stop_reg)
                    && (mode_reg == MODE_DRIVE || mode_reg == MODE_RUP))
                begin
                    lsteer_next = last_reg;
                    rstart_next = now_reg;
                    mode_next   = MODE_RDOWN;
                    if (mode_reg == MODE_DRIVE || rup_reg == '0)
                    begin
                        rfrom_next = FULL;
                        scale_next = FULL;
                    end
                    else
                    begin
                        div_num    = NW'(el_reg) << SCALE_FRAC_BITS;
                        dctl.start = 1'b1;
                        phase_next = 2'd1;
                        st_next    = ST_DIV;
                    end
                end
                else if (uns_reg)
                begin
                    mode_next  = MODE_STEER;
                    scale_next = '0;
                end
                else if (rev_reg)
                    scale_next = '0;
                else if (stop_reg)
                begin
                    mode_next  = MODE_IDLE;
                    scale_next = '0;
                end
                else if (mode_reg == MODE_DRIVE)
                    scale_next = FULL;
                else
                begin
                    if (mode_reg != MODE_RUP)
                    begin
                        rstart_next = now_reg;
                        el_next     = '0;
                        mode_next   = MODE_RUP;
                    end
                    if (rup_reg == '0)
                    begin
                        scale_next = FULL;
                        mode_next  = MODE_DRIVE;
                    end
                    else
                    begin
                        div_num = (mode_reg != MODE_RUP) ? '0
                            : NW'(el_reg) << SCALE_FRAC_BITS;
                        dctl.start = 1'b1;
                        phase_next = 2'd2;
                        st_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (dctl.done)
                begin
                    case (phase_reg)
                        2'd0: scale_next = div_q[SW-1:0];
                        2'd1:
                        begin
                            rfrom_next = up_val;
                            scale_next = up_val;
                        end
                        default:
                        begin
                            scale_next = up_val;
                            if (up_val >= FULL)
                                mode_next = MODE_DRIVE;
                        end
                    endcase
                    st_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mul_start = 1'b1;
                st_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (mul_done)
                begin
                    // truncate toward zero: bias negative products
                    drive_next[16*lane_reg +: 16] = 16'(
                        (mul_p + (mul_p[16+SW] ? (17+SW)'((1 << SCALE_FRAC_BITS) - 1)
                                               : '0)) >>> SCALE_FRAC_BITS);
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == 2'd3)
                    begin
                        if (mode_reg == MODE_RDOWN || stop_reg)
                            steer_next = lsteer_reg;
                        else
                        begin
                            steer_next = tgt_reg;
                            last_next  = tgt_reg;
                        end
                        ov_next = 1'b1;
                        st_next = ST_IDLE;
                    end
                    else
                        st_next = ST_MUL;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            ov_reg     <= 1'b0;
            mode_reg   <= MODE_IDLE;
            rstart_reg <= '0;
            rfrom_reg  <= '0;
            last_reg   <= '0;
            lsteer_reg <= '0;
            lspeed_reg <= '0;
            pvx_reg    <= '0;
            pvy_reg    <= '0;
            phase_reg  <= '0;
            lane_reg   <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            ov_reg     <= ov_next;
            mode_reg   <= mode_next;
            rstart_reg <= rstart_next;
            rfrom_reg  <= rfrom_next;
            last_reg   <= last_next;
            lsteer_reg <= lsteer_next;
            lspeed_reg <= lspeed_next;
            pvx_reg    <= pvx_next;
            pvy_reg    <= pvy_next;
            phase_reg  <= phase_next;
            lane_reg   <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spd_reg   <= spd_next;
        tgt_reg   <= tgt_next;
        stop_reg  <= stop_next;
        uns_reg   <= uns_next;
        rev_reg   <= rev_next;
        now_reg   <= now_next;
        el_reg    <= el_next;
        scale_reg <= scale_next;
        steer_reg <= steer_next;
        drive_reg <= drive_next;
    end

    assign out_valid      = ov_reg;
    assign steer_commands = steer_reg;
    assign drive_commands = drive_reg;
    assign drive_mode     = mode_reg;
    assign drive_scale    = 17'(scale_reg);

`ifndef SYNTH
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("sequencer state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> !in_ready) else $error("input taken while busy");
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_scale <= 17'(FULL)) else $error("scale above full");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_commands))
        else $error("result dropped");
`endif
endmodule

>>> dv/ssrg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_checker: scoreboard for the swerve settle ramp gate
// Follows register writes, predicts one result for every accepted update and
// compares the results leaving the block against them in order.
// ----------------------------------------------------------------------------
module ssrg_checker
    import ssrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    ssrg_if             upd,
    ssrg_if             res,
    output int          err_count,
    output int          pending
);

    localparam int FULL = 65536;

    // register copies
    logic [14:0] thresh, eps;
    logic [31:0] rup_ticks, rdown_ticks, rev_sq;
    logic [63:0] caps;

    // gate state
    logic [2:0]  mode;
    logic [31:0] ramp_start;
    logic [16:0] ramp_from;
    int          last_steer[4], locked_steer[4], locked_speed[4];
    int          prev_vx, prev_vy;

    logic [147:0] gate_results[$];

    assign pending = gate_results.size();

    function automatic int lane(logic [63:0] x, int i);
        return int'(signed'(x[16*i +: 16]));
    endfunction

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [16:0] ramp_up_scale(logic [31:0] elapsed);
        longint unsigned s;
        if (rup_ticks == 0)
            return 17'(FULL);
        s = (longint'(elapsed) * FULL) / longint'(rup_ticks);
        return (s > FULL) ? 17'(FULL) : 17'(s);
    endfunction

    function automatic void begin_ramp_down(logic [31:0] now, logic [31:0] elapsed,
                                            ref logic [16:0] scale);
        for (int i = 0; i < 4; i++)
            locked_steer[i] = last_steer[i];
        ramp_from  = (mode == MODE_DRIVE) ? 17'(FULL) : ramp_up_scale(elapsed);
        ramp_start = now;
        mode       = MODE_RDOWN;
        scale      = ramp_from;
    endfunction

    function automatic logic [147:0] gate_update(logic [271:0] d);
        int          vx, vy, wz, cap, s;
        int          tgt[4], spd[4];
        logic [31:0] now, elapsed;
        logic [63:0] ta, ma, ws, steer_out, drive_out;
        logic [16:0] scale;
        logic        stop, unsettled, reversal;
        longint      dot, psq, csq, dv;
        vx = int'(signed'(d[271:256]));
        vy = int'(signed'(d[255:240]));
        wz = int'(signed'(d[239:224]));
        now = d[223:192];
        ta = d[191:128];
        ma = d[127:64];
        ws = d[63:0];
        elapsed = now - ramp_start;
        scale = '0;
        unsettled = 1'b0;
        steer_out = '0;
        drive_out = '0;
        for (int i = 0; i < 4; i++)
        begin
            cap = lane(caps, i);
            s = lane(ws, i);
            tgt[i] = lane(ta, i);
            spd[i] = (s > cap) ? cap : s;
            if (iabs(tgt[i] - lane(ma, i)) > int'(thresh))
                unsettled = 1'b1;
        end
        stop = iabs(vx) < int'(eps) && iabs(vy) < int'(eps) && iabs(wz) < int'(eps);
        if (!stop)
            for (int i = 0; i < 4; i++)
                locked_speed[i] = spd[i];
        dot = longint'(vx) * prev_vx + longint'(vy) * prev_vy;
        psq = longint'(prev_vx) * prev_vx + longint'(prev_vy) * prev_vy;
        csq = longint'(vx) * vx + longint'(vy) * vy;
        reversal = dot < 0 && psq > longint'(rev_sq) && csq > longint'(rev_sq);

        if (mode == MODE_RDOWN)
        begin
            if (rdown_ticks != 0 && elapsed < rdown_ticks)
                scale = 17'((longint'(ramp_from) * longint'(rdown_ticks - elapsed))
                             / longint'(rdown_ticks));
            else
            begin
                scale = '0;
                if (stop)
                    mode = MODE_IDLE;
                else if (unsettled)
                    mode = MODE_STEER;
                else
                begin
                    mode = MODE_RUP;
                    ramp_start = now;
                end
            end
        end
        else if (unsettled)
        begin
            if (mode == MODE_DRIVE || mode == MODE_RUP)
                begin_ramp_down(now, elapsed, scale);
            else
            begin
                mode = MODE_STEER;
                scale = '0;
            end
        end
        else if (reversal)
        begin
            if (mode == MODE_DRIVE || mode == MODE_RUP)
                begin_ramp_down(now, elapsed, scale);
        end
        else if (stop)
        begin
            if (mode == MODE_DRIVE || mode == MODE_RUP)
                begin_ramp_down(now, elapsed, scale);
            else
            begin
                mode = MODE_IDLE;
                scale = '0;
            end
        end
        else
        begin
            if (mode == MODE_STEER || mode == MODE_IDLE)
            begin
                mode = MODE_RUP;
                ramp_start = now;
                elapsed = '0;
            end
            if (mode == MODE_RUP)
            begin
                scale = ramp_up_scale(elapsed);
                if (scale >= FULL)
                    mode = MODE_DRIVE;
            end
            else
                scale = 17'(FULL);
        end

        for (int i = 0; i < 4; i++)
        begin
            dv = (longint'((mode == MODE_RDOWN) ? locked_speed[i] : spd[i])
                  * longint'(scale)) / FULL;
            drive_out[16*i +: 16] = dv[15:0];
            if (mode == MODE_RDOWN || stop)
                steer_out[16*i +: 16] = 16'(locked_steer[i]);
            else
            begin
                steer_out[16*i +: 16] = 16'(tgt[i]);
                last_steer[i] = tgt[i];
            end
        end
        if (!stop)
        begin
            prev_vx = vx;
            prev_vy = vy;
        end
        return {steer_out, drive_out, mode, scale};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh = 15'd205;
            rup_ticks = 32'd500000;
            rdown_ticks = 32'd500000;
            rev_sq = 32'd164;
            eps = 15'd1;
            caps = 64'hFFFF7FFFFFFFFFFF;
            mode = MODE_IDLE;
            ramp_start = '0;
            ramp_from = '0;
            prev_vx = 0;
            prev_vy = 0;
            for (int i = 0; i < 4; i++)
            begin
                last_steer[i] = 0;
                locked_steer[i] = 0;
                locked_speed[i] = 0;
            end
            gate_results.delete();
            err_count = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_THRESH: thresh = cfg_data[14:0];
                    CFG_RUP:    rup_ticks = cfg_data[31:0];
                    CFG_RDOWN:  rdown_ticks = cfg_data[31:0];
                    CFG_REVSQ:  rev_sq = cfg_data[31:0];
                    CFG_EPS:    eps = cfg_data[14:0];
                    CFG_CAPS:   caps = cfg_data;
                    default:    ;
                endcase
            if (res.valid && res.ready)
            begin
                if (gate_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%t: unexpected result %h", $realtime, res.data);
                end
                else if (gate_results[0] !== res.data)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"%t: mismatch steer exp %h got %h, drive exp %h got %h,",
                                  " mode exp %0d got %0d, scale exp %0d got %0d"},
                                 $realtime, gate_results[0][147:84], res.data[147:84],
                                 gate_results[0][83:20], res.data[83:20],
                                 gate_results[0][19:17], res.data[19:17],
                                 gate_results[0][16:0], res.data[16:0]);
                    void'(gate_results.pop_front());
                end
                else
                    void'(gate_results.pop_front());
            end
            if (upd.valid && upd.ready)
                gate_results.push_back(gate_update(upd.data));
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the swerve settle ramp gate
// Directed corner updates, then phases of random drive sequences under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import ssrg_pkg::*;

    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam int WATCH_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          err_count, pending;
    int          idle_cycles;
    logic        long_hold;
    logic        stim_done;

    ssrg_if #(.W(272)) upd ();
    ssrg_if #(.W(148)) res ();

    // generator state
    logic [15:0] cur_vx, cur_vy, cur_wz;
    logic [31:0] cur_now;
    logic [63:0] cur_tgt;
    int          cur_thresh, cur_eps, t_step;

    swerve_settle_ramp_gate dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (upd.valid),
        .in_ready        (upd.ready),
        .cmd_vx          (upd.data[271:256]),
        .cmd_vy          (upd.data[255:240]),
        .cmd_wz          (upd.data[239:224]),
        .now_time        (upd.data[223:192]),
        .target_angles   (upd.data[191:128]),
        .measured_angles (upd.data[127:64]),
        .wheel_speeds    (upd.data[63:0]),
        .out_valid       (res.valid),
        .out_ready       (res.ready),
        .steer_commands  (res.data[147:84]),
        .drive_commands  (res.data[83:20]),
        .drive_mode      (res.data[19:17]),
        .drive_scale     (res.data[16:0])
    );

    ssrg_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upd       (upd),
        .res       (res),
        .err_count (err_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on accepted requests
    always @(posedge clk)
    begin
        if (upd.valid && upd.ready || res.valid && res.ready || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side with random stalls and one long hold-off
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res.ready = 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 3) == 0)
                res.ready = 1'b1;
            else
            begin
                res.ready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
                res.ready = 1'b1;
            end
            do @(posedge clk); while (!res.valid);
        end
    end

    task automatic send(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz,
                        logic [31:0] now, logic [63:0] tgt, logic [63:0] meas,
                        logic [63:0] spd, int gap);
        if (gap != 0)
        begin
            upd.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        upd.valid = 1'b1;
        upd.data = {vx, vy, wz, now, tgt, meas, spd};
        do @(posedge clk); while (!upd.ready);
        @(negedge clk);
    endtask

    task automatic set_regs(logic [14:0] thr, logic [31:0] rup, logic [31:0] rdown,
                            logic [31:0] revsq, logic [14:0] eps, logic [63:0] caps);
        wait (pending == 0);
        upd.valid = 1'b0;
        repeat (200) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_SPARE;
        cfg_data = {$urandom, $urandom};
        @(negedge clk);
        cfg_index = CFG_THRESH;  cfg_data = 64'(thr);   @(negedge clk);
        cfg_index = CFG_RUP;     cfg_data = 64'(rup);   @(negedge clk);
        cfg_index = CFG_RDOWN;   cfg_data = 64'(rdown); @(negedge clk);
        cfg_index = CFG_REVSQ;   cfg_data = 64'(revsq); @(negedge clk);
        cfg_index = CFG_EPS;     cfg_data = 64'(eps);   @(negedge clk);
        cfg_index = CFG_CAPS;    cfg_data = caps;       @(negedge clk);
        cfg_we = 1'b0;
        cur_thresh = thr;
        cur_eps = eps;
    endtask

    // one update of a drive sequence, with some noise and broken items
    task automatic random_update();
        int          kind, e;
        logic [63:0] meas;
        logic [15:0] d;
        kind = $urandom_range(0, 99);
        cur_now += $urandom_range(0, t_step);
        if (kind < 8)
        begin
            send($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 8));
            return;
        end
        if (kind < 20)
        begin
            // stop command, magnitudes under the epsilon (zero when the epsilon is zero)
            e = (cur_eps > 0) ? cur_eps - 1 : 0;
            cur_vx = 16'($urandom_range(0, 2 * e) - e);
            cur_vy = 16'($urandom_range(0, 2 * e) - e);
            cur_wz = 16'($urandom_range(0, 2 * e) - e);
        end
        else if (kind < 30)
        begin
            // direction reversal
            cur_vx = -cur_vx;
            cur_vy = -cur_vy;
        end
        else if (kind < 45 || cur_vx == 0 && cur_vy == 0)
        begin
            cur_vx = 16'($urandom_range(0, 6000) - 3000);
            cur_vy = 16'($urandom_range(0, 6000) - 3000);
            cur_wz = 16'($urandom_range(0, 2000) - 1000);
        end
        if ($urandom_range(0, 9) == 0)
            cur_tgt = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                d = 16'($urandom);
            else
                d = 16'($urandom_range(0, 2 * cur_thresh) - cur_thresh);
            meas[16*i +: 16] = cur_tgt[16*i +: 16] + d;
        end
        send(cur_vx, cur_vy, cur_wz, cur_now, cur_tgt, meas, {$urandom, $urandom},
             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8));
    endtask

    task automatic random_phase(int count, int step);
        t_step = step;
        for (int n = 0; n < count; n++)
        begin
            if (n == 40 && step == 300)
                long_hold = 1'b1;
            if (n == 60 && step == 300)
                wait (pending == 0);
            random_update();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESH;
        cfg_data = '0;
        upd.valid = 1'b0;
        upd.data = '0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        cur_vx = '0;
        cur_vy = '0;
        cur_wz = '0;
        cur_now = '0;
        cur_tgt = '0;
        cur_thresh = 205;
        cur_eps = 1;
        t_step = 100;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corner updates under the reset settings
        send(16'h0000, 16'h0000, 16'h0000, 32'd0, '0, '0, '0, 0);
        send(16'h0100, 16'h0000, 16'h0000, 32'd10, '0, '0, 64'h7FFF_8000_0100_FF00, 0);
        send(16'h0100, 16'h0000, 16'h0000, 32'd250000, '0, '0, 64'h7FFF_8000_0100_FF00, 1);
        send(16'h0100, 16'h0000, 16'h0000, 32'd600000, '0, '0, 64'h7FFF_8000_0100_FF00, 0);
        send(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd700000, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        // reversal from driving
        send(16'h8000, 16'h8000, 16'h8000, 32'd700100, '0, '0, 64'h1234_5678_9ABC_DEF0, 0);
        send(16'h8000, 16'h8000, 16'h0000, 32'd900000, '0, '0, 64'h1234_5678_9ABC_DEF0, 0);
        send(16'h8000, 16'h8000, 16'h0000, 32'd1300000, '0, '0, 64'h1234_5678_9ABC_DEF0, 0);
        // unsettled steer while ramping up
        send(16'h8000, 16'h8000, 16'h0000, 32'd1300100, 64'h7FFF_8000_7FFF_8000,
             64'h8000_7FFF_8000_7FFF, 64'h0400_0400_0400_0400, 2);
        send(16'h8000, 16'h8000, 16'h0000, 32'd2000000, 64'h7FFF_8000_7FFF_8000,
             64'h7FFF_8000_7FFF_80CD, 64'h0400_0400_0400_0400, 0);
        send(16'h8000, 16'h8000, 16'h0000, 32'd2100000, 64'h7FFF_8000_7FFF_8000,
             64'h7FFF_8000_7FFF_80CE, 64'h0400_0400_0400_0400, 0);
        // stop during a ramp-down, then timestamp wrap
        send(16'h0000, 16'h0000, 16'h0000, 32'd2100100, '0, '0, 64'h0400_0400_0400_0400, 0);
        send(16'h0000, 16'h0000, 16'h0001, 32'hFFFF_FF00, '0, '0, '0, 0);
        send(16'h0040, 16'h0000, 16'h0000, 32'hFFFF_FFF0, 64'h0010_0010_0010_0010,
             64'h0010_0010_0010_0010, 64'h0200_0200_0200_0200, 0);
        send(16'h0040, 16'h0000, 16'h0000, 32'h0003_0000, 64'h0010_0010_0010_0010,
             64'h0010_0010_0010_0010, 64'h0200_0200_0200_0200, 0);

        // settings from small ramps to zero and maximal ones, so sequences reach every mode
        set_regs(15'd205, 32'd2000, 32'd2000, 32'd164, 15'd1, 64'h7FFF_7FFF_7FFF_7FFF);
        random_phase(150, 300);
        set_regs(15'd0, 32'd0, 32'd0, 32'd0, 15'd0, 64'h8000_8000_8000_8000);
        random_phase(120, 200);
        set_regs(15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF,
                 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(100, 32'h0FFF_FFFF);
        set_regs(15'd400, 32'd5000, 32'd0, 32'd1000, 15'd100, 64'h0100_FF00_4000_C000);
        random_phase(150, 1500);
        set_regs(15'd100, 32'd0, 32'd3000, 32'd50, 15'd20, 64'h7FFF_0000_3FFF_8001);
        random_phase(150, 600);
        set_regs(15'd300, 32'd1, 32'd1, 32'd164, 15'd8, 64'hFFFF_7FFF_FFFF_FFFF);
        random_phase(150, 3);
        set_regs(15'd205, 32'd10000, 32'd7000, 32'd164, 15'd1, {$urandom, $urandom});
        random_phase(250, 2500);

        upd.valid = 1'b0;
        stim_done = 1'b1;
        wait (pending == 0);
        repeat (300) @(negedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> swerve_settle_ramp_gate.f
hw/rtl/ssrg_pkg.sv
hw/rtl/ssrg_if.sv
hw/rtl/ssrg_div.sv
hw/rtl/ssrg_mul.sv
hw/rtl/swerve_settle_ramp_gate.sv
dv/ssrg_checker.sv
dv/tb.sv
